### rtl/picv_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the padded
// image CRC verifier. No dependencies; all files but picv_checker import it.
`timescale 1ns / 1ps

package picv_pkg;

    localparam logic [7:0]  FILL_BYTE       = 8'h1A;
    localparam logic [7:0]  ERASED_BYTE     = 8'hFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_SEED_RESET  = 16'h0000;
    localparam logic [7:0]  PAD_LIMIT_RESET = 8'd130;
    localparam logic [7:0]  FILL_RUN_MAX    = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_CRC_SEED  = 1'b0,
        REG_PAD_LIMIT = 1'b1
    } cfg_index_t;

    // Image tracking state as it stands after the current byte.
    typedef struct packed {
        logic [15:0] crc_end;
        logic [15:0] crc_minus_one;
        logic [15:0] crc_minus_two;
        logic [7:0]  high_byte;
        logic [7:0]  low_byte;
        logic [7:0]  fill_run;
        logic        seen_data;
    } snap_t;

    // Result fields of one image verdict.
    typedef struct packed {
        logic        image_valid;
        logic [7:0]  pad_count;
        logic        pad_overflow;
        logic [15:0] end_crc;
    } verdict_t;

    // One byte of CRC-16/XMODEM, MSB first, eight shift steps unrolled.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/padded_image_crc16_verifier_unit.sv
// Top level of the padded image CRC-16 verifier: configuration registers,
// input handshake and the result register. Uses picv_pkg, picv_track, picv_verdict.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+----------------------------------------------
//   input    | in_valid / in_ready  | data_byte, last_byte
//   result   | out_valid / out_ready| image_valid, pad_count, pad_overflow, end_crc
//   config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; the CRC update,
// snapshot and verdict all settle in the cycle of the transfer, and the
// verdict appears in the result register on the next cycle. in_ready is low
// only while a result is held and out_ready is low. Reset clears the
// configuration to its defaults and ends any image in progress.
`timescale 1ns / 1ps

module padded_image_crc16_verifier_unit
    import picv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        image_valid,
    output logic [7:0]  pad_count,
    output logic        pad_overflow,
    output logic [15:0] end_crc,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] crc_seed_reg;
    logic [7:0]  pad_limit_reg;
    logic        out_valid_reg;
    verdict_t    result_reg;

    logic        accept;
    snap_t       snap_next;
    verdict_t    verdict;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    picv_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .crc_seed  (crc_seed_reg),
        .snap_next (snap_next)
    );

    picv_verdict u_verdict (
        .snap      (snap_next),
        .pad_limit (pad_limit_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_seed_reg  <= CRC_SEED_RESET;
            pad_limit_reg <= PAD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CRC_SEED:  crc_seed_reg  <= cfg_data;
                REG_PAD_LIMIT: pad_limit_reg <= cfg_data[7:0];
                default:       crc_seed_reg  <= crc_seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            result_reg <= verdict;
        end
    end

    assign out_valid    = out_valid_reg;
    assign image_valid  = result_reg.image_valid;
    assign pad_count    = result_reg.pad_count;
    assign pad_overflow = result_reg.pad_overflow;
    assign end_crc      = result_reg.end_crc;

endmodule

### rtl/picv_track.sv
// Per-byte image tracking: running CRC history, snapshot at the latest
// non-fill byte and the trailing fill run. Depends on picv_pkg.
`timescale 1ns / 1ps

module picv_track
    import picv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] crc_seed,
    output snap_t       snap_next
);

    logic        in_image_reg;
    logic [15:0] running_crc_reg;
    logic [15:0] crc_one_back_reg;
    logic [7:0]  previous_byte_reg;
    snap_t       snap_reg;

    logic [15:0] base_run;
    logic [15:0] base_one;
    logic [7:0]  base_prev;
    snap_t       base_snap;
    logic [15:0] crc_next;

    // The first byte of an image starts from the seed, whatever was left behind.
    always_comb
    begin
        if (in_image_reg)
        begin
            base_run  = running_crc_reg;
            base_one  = crc_one_back_reg;
            base_prev = previous_byte_reg;
            base_snap = snap_reg;
        end
        else
        begin
            base_run  = crc_seed;
            base_one  = crc_seed;
            base_prev = '0;
            base_snap = '{crc_end: crc_seed, crc_minus_one: crc_seed,
                          crc_minus_two: crc_seed, high_byte: '0, low_byte: '0,
                          fill_run: '0, seen_data: 1'b0};
        end
    end

    assign crc_next = crc_byte(base_run, data_byte);

    always_comb
    begin
        snap_next = base_snap;
        if (data_byte != FILL_BYTE)
        begin
            snap_next.crc_end       = crc_next;
            snap_next.crc_minus_one = base_run;
            snap_next.crc_minus_two = base_one;
            snap_next.high_byte     = base_prev;
            snap_next.low_byte      = data_byte;
            snap_next.seen_data     = 1'b1;
            snap_next.fill_run      = '0;
        end
        else if (base_snap.fill_run != FILL_RUN_MAX)
        begin
            snap_next.fill_run = base_snap.fill_run + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_image_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_image_reg <= !last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            running_crc_reg   <= crc_next;
            crc_one_back_reg  <= base_run;
            previous_byte_reg <= data_byte;
            snap_reg          <= snap_next;
        end
    end

endmodule

### rtl/picv_verdict.sv
// Verdict logic: compares the three stored-CRC candidates against the
// snapshot and applies the fill limit. Depends on picv_pkg.
`timescale 1ns / 1ps

module picv_verdict
    import picv_pkg::*;
(
    input  snap_t      snap,
    input  logic [7:0] pad_limit,
    output verdict_t   verdict
);

    logic        over;
    logic [7:0]  after1;
    logic [7:0]  after2;
    logic [15:0] code1;
    logic [15:0] code2;
    logic [15:0] code3;
    logic        match;

    // Bytes past the data are fill if the run covers them, erased flash otherwise.
    assign over   = snap.fill_run > pad_limit;
    assign after1 = (snap.fill_run >= 8'd1) ? FILL_BYTE : ERASED_BYTE;
    assign after2 = (snap.fill_run >= 8'd2) ? FILL_BYTE : ERASED_BYTE;
    assign code1  = {snap.high_byte, snap.low_byte};
    assign code2  = {snap.low_byte, after1};
    assign code3  = {after1, after2};
    assign match  = (code1 == snap.crc_minus_two) || (code2 == snap.crc_minus_one)
                 || (code3 == snap.crc_end);

    assign verdict.image_valid  = snap.seen_data && !over && match;
    assign verdict.pad_count    = over ? pad_limit : snap.fill_run;
    assign verdict.pad_overflow = over;
    assign verdict.end_crc      = snap.crc_end;

endmodule

### rtl/picv_checker.sv
// Port-level checks for padded_image_crc16_verifier_unit, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module picv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic        image_valid,
    input logic [7:0]  pad_count,
    input logic        pad_overflow,
    input logic [15:0] end_crc
);

    // A held result must not change until its transfer.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(end_crc)
            && $stable(pad_count) && $stable(image_valid) && $stable(pad_overflow))
        else $error("result changed while stalled");

    // The final byte of an image always produces a verdict on the next cycle.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte |=> out_valid)
        else $error("no verdict after last byte");

    // The input side is only held back by a pending result.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no pending result");

    // An overflowing fill run can never give a valid image.
    a_overflow_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pad_overflow |-> !image_valid)
        else $error("valid image reported with fill overflow");

endmodule

bind padded_image_crc16_verifier_unit picv_checker u_picv_checker (.*);

### tb/sv/tb_padded_image_crc16_verifier_unit.sv
// Self-checking testbench for padded_image_crc16_verifier_unit: streams firmware
// images with embedded CRCs and fill runs, predicts each verdict and compares it.
// Depends on rtl/picv_pkg.sv and the unit's RTL.
`timescale 1ns / 1ps

module tb_padded_image_crc16_verifier_unit
    import picv_pkg::*;
();

    localparam int LONG_HOLD = 300;

    typedef enum {
        IMG_NOISE,
        IMG_CODE1,
        IMG_CODE2,
        IMG_CODE3,
        IMG_BROKEN
    } image_kind_t;

    // Tracks one image at a time and queues the verdict that each last byte implies.
    class crc_verdict_board;
        logic [15:0] seed;
        logic [7:0]  limit;
        logic [15:0] crc_now, crc_back1, crc_back2;
        logic [15:0] mark_end, mark_back1, mark_back2;
        logic [7:0]  mark_hi, mark_lo, prior, fills;
        bit          got_data;
        bit          open;
        verdict_t    verdicts[$];
        int          errors;

        function new();
            seed = CRC_SEED_RESET;
            limit = PAD_LIMIT_RESET;
            open = 1'b0;
            errors = 0;
        endfunction

        // Bit-serial CRC-16/XMODEM over one byte, MSB first.
        static function logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            logic        feedback;
            c = crc;
            for (int i = 7; i >= 0; i--)
            begin
                feedback = c[15] ^ b[i];
                c = {c[14:0], 1'b0};
                if (feedback)
                begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [15:0] nxt;
            logic [7:0]  after1, after2;
            bit          over, hit;
            verdict_t    v;
            if (!open)
            begin
                crc_now = seed;
                crc_back1 = seed;
                crc_back2 = seed;
                mark_end = seed;
                mark_back1 = seed;
                mark_back2 = seed;
                mark_hi = 8'h00;
                mark_lo = 8'h00;
                prior = 8'h00;
                fills = 8'h00;
                got_data = 1'b0;
                open = 1'b1;
            end
            nxt = crc_add(crc_now, b);
            crc_back2 = crc_back1;
            crc_back1 = crc_now;
            crc_now = nxt;
            if (b != FILL_BYTE)
            begin
                mark_end = crc_now;
                mark_back1 = crc_back1;
                mark_back2 = crc_back2;
                mark_hi = prior;
                mark_lo = b;
                got_data = 1'b1;
                fills = 8'h00;
            end
            else if (fills != FILL_RUN_MAX)
            begin
                fills = fills + 8'd1;
            end
            prior = b;
            if (last)
            begin
                over = fills > limit;
                after1 = (fills >= 8'd1) ? FILL_BYTE : ERASED_BYTE;
                after2 = (fills >= 8'd2) ? FILL_BYTE : ERASED_BYTE;
                hit = ({mark_hi, mark_lo} == mark_back2) || ({mark_lo, after1} == mark_back1)
                      || ({after1, after2} == mark_end);
                v.image_valid = got_data && !over && hit;
                v.pad_count = over ? limit : fills;
                v.pad_overflow = over;
                v.end_crc = mark_end;
                verdicts.push_back(v);
                open = 1'b0;
            end
        endfunction

        function void check(verdict_t got);
            verdict_t want;
            if (verdicts.size() == 0)
            begin
                $error("verdict with no image pending: end_crc %h", got.end_crc);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (got.image_valid !== want.image_valid)
            begin
                $error("image_valid: expected %0d, actual %0d", want.image_valid,
                       got.image_valid);
                errors++;
            end
            if (got.pad_count !== want.pad_count)
            begin
                $error("pad_count: expected %0d, actual %0d", want.pad_count, got.pad_count);
                errors++;
            end
            if (got.pad_overflow !== want.pad_overflow)
            begin
                $error("pad_overflow: expected %0d, actual %0d", want.pad_overflow,
                       got.pad_overflow);
                errors++;
            end
            if (got.end_crc !== want.end_crc)
            begin
                $error("end_crc: expected %h, actual %h", want.end_crc, got.end_crc);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        image_valid;
    logic [7:0]  pad_count;
    logic        pad_overflow;
    logic [15:0] end_crc;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    crc_verdict_board board;
    logic [7:0]       img[$];
    // Maps a target CRC to the 16-bit value that, XORed into the register and
    // pushed through two zero bytes, produces it.
    logic [15:0]      crc_pre[0:65535];
    logic [15:0]      cur_seed = CRC_SEED_RESET;
    logic [7:0]       cur_limit = PAD_LIMIT_RESET;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    bit               stall_request = 1'b0;

    padded_image_crc16_verifier_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .image_valid  (image_valid),
        .pad_count    (pad_count),
        .pad_overflow (pad_overflow),
        .end_crc      (end_crc),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Appends the stored CRC that the chosen kind calls for, if any, then the fill run.
    function automatic void finish_image(image_kind_t kind, int fill_len);
        logic [15:0] c;
        logic [15:0] x;
        logic [7:0]  hi, after1, after2;
        int          spot;
        c = cur_seed;
        foreach (img[i])
        begin
            c = crc_verdict_board::crc_add(c, img[i]);
        end
        after1 = (fill_len >= 1) ? FILL_BYTE : ERASED_BYTE;
        after2 = (fill_len >= 2) ? FILL_BYTE : ERASED_BYTE;
        case (kind)
            IMG_CODE1, IMG_BROKEN:
            begin
                img.push_back(c[15:8]);
                img.push_back(c[7:0]);
                if (kind == IMG_BROKEN)
                begin
                    spot = $urandom_range(img.size() - 1);
                    img[spot] = img[spot] ^ (8'h01 << $urandom_range(7));
                end
            end
            IMG_CODE2:
            begin
                // Steer the CRC so that the byte after the data completes code2.
                do
                begin
                    hi = 8'($urandom_range(255));
                end
                while (hi == FILL_BYTE);
                x = c ^ crc_pre[{hi, after1}];
                img.push_back(x[15:8]);
                img.push_back(x[7:0]);
                img.push_back(hi);
            end
            IMG_CODE3:
            begin
                x = c ^ crc_pre[{after1, after2}];
                img.push_back(x[15:8]);
                img.push_back(x[7:0]);
            end
            default:
            begin
            end
        endcase
        repeat (fill_len) img.push_back(FILL_BYTE);
        if (img.size() == 0)
        begin
            img.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic void build_image(image_kind_t kind, int data_len, int fill_len);
        img.delete();
        repeat (data_len)
        begin
            img.push_back(($urandom_range(7) == 0) ? FILL_BYTE : 8'($urandom_range(255)));
        end
        finish_image(kind, fill_len);
    endfunction

    // Called at a rising edge; returns at the edge of the final transfer.
    task automatic send_image();
        foreach (img[i])
        begin
            if ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while ($urandom_range(99) < send_idle_pct);
            end
            in_valid <= 1'b1;
            data_byte <= img[i];
            last_byte <= (i == img.size() - 1);
            do
            begin
                @(posedge clk);
            end
            while (!in_ready);
            board.note_byte(img[i], i == img.size() - 1);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [15:0] seed, input logic [7:0] limit);
        cfg_we <= 1'b1;
        cfg_index <= REG_CRC_SEED;
        cfg_data <= seed;
        @(posedge clk);
        cfg_index <= REG_PAD_LIMIT;
        cfg_data <= {8'h00, limit};
        @(posedge clk);
        cfg_we <= 1'b0;
        board.seed = seed;
        board.limit = limit;
        cur_seed = seed;
        cur_limit = limit;
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                stall_request = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check({image_valid, pad_count, pad_overflow, end_crc});
        end
    end

    initial
    begin
        int          phase_items;
        int          data_len;
        int          fill_len;
        int          pick;
        logic [15:0] seed_val;
        logic [7:0]  limit_val;
        image_kind_t kind;

        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CRC_SEED;
        cfg_data = 16'h0000;
        for (int y = 0; y < 65536; y++)
        begin
            crc_pre[crc_verdict_board::crc_add(crc_verdict_board::crc_add(16'(y), 8'h00),
                                               8'h00)] = 16'(y);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed images; the first five use the reset configuration. A lone zero byte
        // matches code1 because the byte before the image start counts as zero.
        img = '{8'h00};
        finish_image(IMG_NOISE, 0);
        send_image();
        img.delete();
        finish_image(IMG_NOISE, 2);
        send_image();
        img = '{8'h00, 8'hFF};
        finish_image(IMG_CODE1, 1);
        send_image();
        img.delete();
        finish_image(IMG_CODE2, 0);
        send_image();
        img.delete();
        finish_image(IMG_CODE3, 2);
        send_image();
        wait_idle();
        apply_config(16'hFFFF, 8'd1);
        img = '{8'h7F};
        finish_image(IMG_CODE1, 2);
        send_image();
        img.delete();
        finish_image(IMG_CODE1, 1);
        send_image();

        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            case (p)
                0: begin seed_val = 16'h0000; limit_val = 8'd255; end
                1: begin seed_val = 16'hFFFF; limit_val = 8'd1; end
                2:
                begin
                    seed_val = 16'($urandom_range(65535));
                    limit_val = 8'($urandom_range(2, 12));
                end
                3: begin seed_val = 16'($urandom_range(65535)); limit_val = PAD_LIMIT_RESET; end
                4: begin seed_val = 16'h1D0F; limit_val = 8'($urandom_range(13, 254)); end
                default:
                begin
                    seed_val = 16'($urandom_range(65535));
                    limit_val = 8'($urandom_range(2, 12));
                end
            endcase
            apply_config(seed_val, limit_val);
            case (p / 2)
                0: begin send_idle_pct = 14; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (p == 4)
            begin
                stall_request = 1'b1;
            end
            // A fill run just past the limit; at the maximum limit the count saturates.
            if (cur_limit == 8'd255 || cur_limit == PAD_LIMIT_RESET || cur_limit <= 8'd12)
            begin
                build_image(IMG_CODE1, 3, int'(cur_limit) + 1 + $urandom_range(2));
                send_image();
            end
            phase_items = 0;
            while (phase_items < 200)
            begin
                pick = $urandom_range(9);
                case (pick)
                    0, 1: kind = IMG_NOISE;
                    2, 3, 4: kind = IMG_CODE1;
                    5, 6: kind = IMG_CODE2;
                    7: kind = IMG_CODE3;
                    default: kind = IMG_BROKEN;
                endcase
                data_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(6);
                pick = $urandom_range(9);
                if (pick <= 3)
                begin
                    fill_len = 0;
                end
                else if (pick <= 6)
                begin
                    fill_len = $urandom_range(1, 2);
                end
                else if (pick == 9 && cur_limit <= 8'd12)
                begin
                    fill_len = $urandom_range(int'(cur_limit) - 1, int'(cur_limit) + 2);
                end
                else
                begin
                    fill_len = $urandom_range(3, 6);
                end
                build_image(kind, data_len, fill_len);
                send_image();
                phase_items += img.size();
            end
        end

        in_valid <= 1'b0;
        for (int n = 0; n < 20000 && board.pending() != 0; n++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d verdicts never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/picv_pkg.sv
rtl/picv_track.sv
rtl/picv_verdict.sv
rtl/padded_image_crc16_verifier_unit.sv
rtl/picv_checker.sv
tb/sv/tb_padded_image_crc16_verifier_unit.sv
